// ===== hdl/dfc_pkg.sv =====
`timescale 1ns / 1ps

package dfc_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_HEADER  = 2'd0,
    REG_MIN     = 2'd1,
    REG_MAX     = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_index_t;

  // frame status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CHECKSUM  = 2'd1,
    ST_BELOW_MIN = 2'd2,
    ST_ABOVE_MAX = 2'd3
  } status_t;

  // byte position within a frame
  typedef enum logic [1:0] {
    POS_HUNT     = 2'd0,
    POS_HIGH     = 2'd1,
    POS_LOW      = 2'd2,
    POS_CHECKSUM = 2'd3
  } pos_t;

  localparam logic [7:0]  HEADER_RESET = 8'd255;
  localparam logic [15:0] MIN_RESET    = 16'd30;
  localparam logic [15:0] MAX_RESET    = 16'd4500;

  typedef struct packed {
    logic [7:0]  header_value;
    logic [15:0] lower_limit;
    logic [15:0] upper_limit;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] distance;
    logic [15:0] raw_distance;
  } result_t;

endpackage

// ===== hdl/dfc_rx_stage.sv =====
`timescale 1ns / 1ps

module dfc_rx_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       step,
  output logic       b_valid,
  output logic [7:0] b_data
);

  // slot is free when empty, or when the held byte moves on this cycle
  assign in_ready = !b_valid || step;

  // valid flag for the held byte
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_ready) begin
      b_valid <= in_valid;
    end
  end

  // byte register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_data <= rx_byte;
    end
  end

endmodule

// ===== hdl/dfc_parse.sv =====
`timescale 1ns / 1ps

module dfc_parse (
  input  logic             clk,
  input  logic             rst,
  input  dfc_pkg::cfg_t    cfg,
  input  logic             b_valid,
  input  logic [7:0]       b_data,
  input  logic             o_free,
  output logic             step,
  output logic             emit,
  output dfc_pkg::result_t result
);

  import dfc_pkg::*;

  pos_t        pos;
  pos_t        pos_next;
  logic [7:0]  high_byte;
  logic [7:0]  low_byte;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [15:0] raw;
  status_t     status;

  // a checksum byte needs room in the result register
  assign emit = b_valid && (pos == POS_CHECKSUM);
  assign step = b_valid && (!emit || o_free);

  // position and running sum update
  always_comb begin
    pos_next         = pos;
    running_sum_next = running_sum;
    unique case (pos)
      POS_HUNT: begin
        if (b_data == cfg.header_value) begin
          pos_next         = POS_HIGH;
          running_sum_next = b_data;
        end
      end
      POS_HIGH: begin
        pos_next         = POS_LOW;
        running_sum_next = running_sum + b_data;
      end
      POS_LOW: begin
        pos_next         = POS_CHECKSUM;
        running_sum_next = running_sum + b_data;
      end
      POS_CHECKSUM: begin
        pos_next = POS_HUNT;
      end
      default: begin
        pos_next = POS_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HUNT;
      high_byte   <= '0;
      low_byte    <= '0;
      running_sum <= '0;
    end else if (step) begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
      if (pos == POS_HIGH) begin
        high_byte <= b_data;
      end
      if (pos == POS_LOW) begin
        low_byte <= b_data;
      end
    end
  end

  // frame checks, in priority order
  assign raw = {high_byte, low_byte};

  always_comb begin
    if (running_sum != b_data) begin
      status = ST_CHECKSUM;
    end else if (raw < cfg.lower_limit) begin
      status = ST_BELOW_MIN;
    end else if (raw > cfg.upper_limit) begin
      status = ST_ABOVE_MAX;
    end else begin
      status = ST_OK;
    end
  end

  assign result.status       = status;
  assign result.distance     = (status == ST_OK) ? raw : cfg.lower_limit;
  assign result.raw_distance = raw;

endmodule

// ===== hdl/dfc_out_reg.sv =====
`timescale 1ns / 1ps

module dfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dfc_pkg::result_t result,
  output logic             o_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [15:0]      distance,
  output logic [15:0]      raw_distance
);

  import dfc_pkg::*;

  result_t held;

  // empty, or emptied by a transfer this cycle
  assign o_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && o_free) begin
      held <= result;
    end
  end

  assign status       = 2'(held.status);
  assign distance     = held.distance;
  assign raw_distance = held.raw_distance;

endmodule

// ===== hdl/distance_frame_checker_core.sv =====
`timescale 1ns / 1ps

// path: out_valid rises once the checksum byte has passed the byte register,
// then the result register
// throughput: one byte per cycle, the frame checks being combinational;
// a result held by the receiver stalls the checksum byte and then the input
// reset: synchronous, clears position, sums and valid flags and loads the
// default header, minimum and maximum; no clearing pass
module distance_frame_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] distance,
  output logic [15:0] raw_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import dfc_pkg::*;

  cfg_t       cfg;
  logic       step;
  logic       emit;
  logic       b_valid;
  logic [7:0] b_data;
  logic       o_free;
  result_t    result;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value <= HEADER_RESET;
      cfg.lower_limit  <= MIN_RESET;
      cfg.upper_limit  <= MAX_RESET;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_HEADER: cfg.header_value <= cfg_data[7:0];
        REG_MIN:    cfg.lower_limit  <= cfg_data;
        REG_MAX:    cfg.upper_limit  <= cfg_data;
        default:    ;
      endcase
    end
  end

  dfc_rx_stage u_rx (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .step     (step),
    .b_valid  (b_valid),
    .b_data   (b_data)
  );

  dfc_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .b_valid (b_valid),
    .b_data  (b_data),
    .o_free  (o_free),
    .step    (step),
    .emit    (emit),
    .result  (result)
  );

  dfc_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .result       (result),
    .o_free       (o_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .distance     (distance),
    .raw_distance (raw_distance)
  );

endmodule
